FILE: rtl/tsp_pkg.sv
// ============================================================================
// tsp_pkg - shared types and constants for the timer slot pool
// Holds the pool size, index widths, mode and status codes, and the
// command/status structs between the controller and the datapath.
// ============================================================================
`default_nettype none

package tsp_pkg;

   // pool size (1..15)
   localparam int NUM_SLOTS  = 8;
   localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // item field widths
   localparam int MODE_W   = 2;
   localparam int DATA_W   = 32;
   localparam int ID_W     = 4;
   localparam int STATUS_W = 2;
   // one-based ids are compared against the pool size at this width
   localparam int ID_EXT_W = 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_START = 2'd0,
      MODE_QUERY = 2'd1,
      MODE_STOP  = 2'd2,
      MODE_TICK  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_INVALID   = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;    // latch the accepted item
      logic exec;       // start, query or stop: update slot and load result
      logic tick_step;  // advance one slot of a tick walk
      logic finish;     // load the ok result that ends a tick
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;   // result register can take a new item this cycle
      logic is_tick;    // captured item is a tick
      logic walk_last;  // walk pointer is on the last slot
   } sts_type;

endpackage : tsp_pkg

`default_nettype wire

FILE: rtl/timer_slot_pool_core.sv
// ============================================================================
// timer_slot_pool_core - pool of software-style timer slots
// Top level: joins the sequencer and the slot datapath.
// ============================================================================
// Usage:
//   Input channel req_*: one item per handshake, carrying mode (start,
//   query, stop, tick), duration, slot_id and tick_ms. Accepted at a clock
//   edge with req_valid high and req_stall low.
//   Result channel rsp_*: exactly one item (status, new_id, expired_flag)
//   per input item, in order, held in an output register.
//   Sequencing: start, query and stop pass through the execute state, which
//   loads the result register and reopens the input in the same cycle. A
//   tick goes from the execute state to the walk state, which walks the
//   slots one per cycle through a single read and write port of the slot
//   storage, and then to the finish state, which loads the result and
//   reopens the input. One item is in work at a time.
//   Stall: while rsp_stall holds a result, the next item may still be
//   accepted and worked on; its result waits in the last step until the
//   output register is taken, and the input stays closed meanwhile.
//   Reset (synchronous, active high): all slots become inactive, the
//   result register empties, the input is open in the next cycle.
// ============================================================================
`default_nettype none

module timer_slot_pool_core
   import tsp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // input items
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [MODE_W-1:0]   req_mode,
   input  wire logic [DATA_W-1:0]   req_duration,
   input  wire logic [ID_W-1:0]     req_slot_id,
   input  wire logic [DATA_W-1:0]   req_tick_ms,
   // result items
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [ID_W-1:0]          rsp_new_id,
   output logic                     rsp_expired_flag
);

   cmd_type cmd;
   sts_type sts;

   tsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   tsp_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_mode         (req_mode),
      .req_duration     (req_duration),
      .req_slot_id      (req_slot_id),
      .req_tick_ms      (req_tick_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_new_id       (rsp_new_id),
      .rsp_expired_flag (rsp_expired_flag),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule : timer_slot_pool_core

`default_nettype wire

FILE: rtl/tsp_datapath.sv
// ============================================================================
// tsp_datapath - slot storage, item registers and result register
// Keeps the active flags, elapsed counts and durations of the pool, runs
// the slot walk for tick items and holds the result until it is taken.
// ============================================================================
`default_nettype none

module tsp_datapath
   import tsp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // input item fields
   input  wire logic [MODE_W-1:0]   req_mode,
   input  wire logic [DATA_W-1:0]   req_duration,
   input  wire logic [ID_W-1:0]     req_slot_id,
   input  wire logic [DATA_W-1:0]   req_tick_ms,
   // result channel
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [ID_W-1:0]          rsp_new_id,
   output logic                     rsp_expired_flag,
   // control
   input  wire cmd_type             cmd,
   output sts_type                  sts
);

   // captured item
   mode_type                  mode_ff;
   logic [DATA_W-1:0]         dur_ff;
   logic [ID_W-1:0]           id_ff;
   logic [DATA_W-1:0]         tick_ff;
   logic [SLOT_IDX_W-1:0]     walk_idx_ff;

   // slot storage
   logic [NUM_SLOTS-1:0]      active_ff;
   logic [NUM_SLOTS-1:0]      active_in;
   logic [DATA_W-1:0]         elapsed_mem [NUM_SLOTS];
   logic [DATA_W-1:0]         duration_mem [NUM_SLOTS];

   // result register
   logic                      rsp_valid_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic [ID_W-1:0]           rsp_new_id_ff;
   logic                      rsp_expired_ff;
   status_type                res_status;
   logic [ID_W-1:0]           res_new_id;
   logic                      res_expired;
   logic                      load;

   // decode of the captured slot id
   logic [ID_EXT_W-1:0]       id_ext;
   logic [ID_EXT_W-1:0]       id_m1;
   logic                      id_bad;
   logic [SLOT_IDX_W-1:0]     id_idx;

   // lowest free slot
   logic                      free_found;
   logic [SLOT_IDX_W-1:0]     free_idx;

   // shared read port and tick arithmetic
   logic [SLOT_IDX_W-1:0]     rd_idx;
   logic [DATA_W-1:0]         rd_elapsed;
   logic [DATA_W-1:0]         rd_duration;
   logic [DATA_W:0]           tick_sum;
   logic [DATA_W-1:0]         tick_elapsed;

   logic                      start_ok;

   // item capture and walk pointer
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= mode_type'(req_mode);
         dur_ff  <= req_duration;
         id_ff   <= req_slot_id;
         tick_ff <= req_tick_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_idx_ff <= '0;
      end else if (cmd.capture) begin
         walk_idx_ff <= '0;
      end else if (cmd.tick_step) begin
         walk_idx_ff <= sts.walk_last ? '0 : walk_idx_ff + 1'b1;
      end
   end

   // slot id check and index
   assign id_ext = ID_EXT_W'(id_ff);
   assign id_m1  = id_ext - ID_EXT_W'(1);
   assign id_bad = (id_ext == '0) || (id_ext > ID_EXT_W'(NUM_SLOTS));
   assign id_idx = id_m1[SLOT_IDX_W-1:0];

   // lowest inactive slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
         if (!active_ff[k]) begin
            free_found = 1'b1;
            free_idx   = SLOT_IDX_W'(k);
         end
      end
   end

   // one read port: walk pointer during a tick, else the item's slot
   assign rd_idx      = cmd.tick_step ? walk_idx_ff : id_idx;
   assign rd_elapsed  = elapsed_mem[rd_idx];
   assign rd_duration = duration_mem[rd_idx];

   // saturating add of the tick time
   assign tick_sum     = {1'b0, rd_elapsed} + {1'b0, tick_ff};
   assign tick_elapsed = (tick_sum >= {1'b0, rd_duration}) ? rd_duration
                                                           : tick_sum[DATA_W-1:0];

   assign start_ok = (mode_ff == MODE_START) && (dur_ff != '0) && free_found;

   // result of the executed item and the active flag update
   always_comb begin
      res_status  = ST_OK;
      res_new_id  = '0;
      res_expired = 1'b0;
      active_in   = active_ff;
      if (cmd.exec) begin
         case (mode_ff)
            MODE_START: begin
               if (dur_ff == '0) begin
                  res_status = ST_INVALID;
               end else if (!free_found) begin
                  res_status = ST_FULL;
               end else begin
                  res_new_id          = ID_W'(free_idx) + ID_W'(1);
                  active_in[free_idx] = 1'b1;
               end
            end
            MODE_QUERY, MODE_STOP: begin
               if (id_bad) begin
                  res_status = ST_INVALID;
               end else if (!active_ff[id_idx]) begin
                  res_status = ST_NOT_FOUND;
               end else if (mode_ff == MODE_QUERY) begin
                  res_expired = (rd_elapsed >= rd_duration);
               end else begin
                  active_in[id_idx] = 1'b0;
               end
            end
            default: begin
               res_status = ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else begin
         active_ff <= active_in;
      end
   end

   // slot storage writes; values read from inactive slots are never used
   always_ff @(posedge clock) begin
      if (cmd.exec && start_ok) begin
         elapsed_mem[free_idx]  <= '0;
         duration_mem[free_idx] <= dur_ff;
      end else if (cmd.tick_step && active_ff[walk_idx_ff]) begin
         elapsed_mem[walk_idx_ff] <= tick_elapsed;
      end
   end

   // result register
   assign load = cmd.exec || cmd.finish;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_status_ff  <= cmd.exec ? res_status : ST_OK;
         rsp_new_id_ff  <= cmd.exec ? res_new_id : '0;
         rsp_expired_ff <= cmd.exec ? res_expired : 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_new_id       = rsp_new_id_ff;
   assign rsp_expired_flag = rsp_expired_ff;

   // status to controller
   always_comb begin
      sts           = '0;
      sts.out_free  = !rsp_valid_ff || !rsp_stall;
      sts.is_tick   = (mode_ff == MODE_TICK);
      sts.walk_last = (walk_idx_ff == SLOT_IDX_W'(NUM_SLOTS - 1));
   end

   // a result is only loaded into a free result register
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> sts.out_free)
      else $error("result loaded while previous result stalled");

   // exec never overlaps the tick walk or the finish step
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.exec && cmd.tick_step) && !(cmd.exec && cmd.finish))
      else $error("conflicting datapath commands");

   // walk pointer wraps to zero after the last slot
   a_walk_wrap: assert property (@(posedge clock) disable iff (reset)
      (cmd.tick_step && sts.walk_last && !cmd.capture) |=> (walk_idx_ff == '0))
      else $error("walk pointer did not wrap");

endmodule : tsp_datapath

`default_nettype wire

FILE: rtl/tsp_ctrl.sv
// ============================================================================
// tsp_ctrl - sequencer of the timer slot pool
// Accepts one item at a time, issues the execute step or the per-slot tick
// walk, and waits for the result register before finishing the item.
// ============================================================================
`default_nettype none

module tsp_ctrl
   import tsp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   output cmd_type      cmd,
   input  wire sts_type sts
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_WALK,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.capture   = accept;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (sts.is_tick) begin
               state_in = S_WALK;
            end else if (sts.out_free) begin
               cmd.exec = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_WALK: begin
            cmd.tick_step = 1'b1;
            if (sts.walk_last) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // an accepted item closes the input until it is done
   a_accept_stall: assert property (@(posedge clock) disable iff (reset)
      accept |=> req_stall)
      else $error("input reopened right after accept");

   // finish is only reached through the tick walk
   a_finish_from_walk: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == S_FINISH) |-> ($past(state_ff) == S_WALK))
      else $error("finish entered without a tick walk");

   // the walk is entered only for tick items
   a_walk_tick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && state_in == S_WALK) |-> sts.is_tick)
      else $error("walk started for a non-tick item");

endmodule : tsp_ctrl

`default_nettype wire

FILE: dv/timer_slot_pool_core_test.sv
// ============================================================================
// timer_slot_pool_core_test - self-checking bench for the timer slot pool
// Drives start, query, stop and tick items through the request channel and checks every
// result against an in-bench model of the slot pool or a pinned row's own result. A short
// directed table covers the edge cases, then about 1600 random items follow,
// with bursty input, random output stalls and one long output hold-off.
// ============================================================================
module timer_slot_pool_core_test
   import tsp_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES  = 300;
   localparam int SEG_ITEMS    = 400;
   localparam int SEGMENTS     = 4;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int DIRECTED_N   = 26;
   localparam logic [DATA_W-1:0] ALL_ONES = '1;

   // one result item
   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   new_id;
      logic              expired_flag;
   } pool_result_type;

   // one stimulus row; pinned rows carry their own expected result
   typedef struct packed {
      mode_type          mode;
      logic [DATA_W-1:0] duration;
      logic [ID_W-1:0]   slot_id;
      logic [DATA_W-1:0] tick_ms;
      logic              pinned;
      status_type        exp_status;
      logic [ID_W-1:0]   exp_id;
      logic              exp_flag;
   } stim_row_type;

   // directed items, walked in order from reset
   localparam stim_row_type DIRECTED [DIRECTED_N] = '{
      // empty pool, unused fields at all ones
      '{MODE_QUERY, ALL_ONES,      4'd1,  ALL_ONES, 1'b1, ST_NOT_FOUND, 4'd0, 1'b0},
      // bad ids: zero and above the pool size
      '{MODE_STOP,  32'd0,         4'd0,  32'd0,    1'b1, ST_INVALID,   4'd0, 1'b0},
      '{MODE_QUERY, 32'd0,         4'd15, 32'd0,    1'b1, ST_INVALID,   4'd0, 1'b0},
      '{MODE_STOP,  32'd0,         4'd9,  32'd0,    1'b1, ST_INVALID,   4'd0, 1'b0},
      // zero duration is rejected
      '{MODE_START, 32'd0,         4'd15, ALL_ONES, 1'b1, ST_INVALID,   4'd0, 1'b0},
      '{MODE_START, 32'd1,         4'd0,  32'd0,    1'b1, ST_OK,        4'd1, 1'b0},
      '{MODE_START, ALL_ONES,      4'd0,  32'd0,    1'b1, ST_OK,        4'd2, 1'b0},
      '{MODE_START, 32'd5,         4'd0,  32'd0,    1'b1, ST_OK,        4'd3, 1'b0},
      '{MODE_TICK,  32'd0,         4'd0,  32'd0,    1'b1, ST_OK,        4'd0, 1'b0},
      // slot 1 saturates at its duration, slot 3 goes part way
      '{MODE_TICK,  ALL_ONES,      4'd15, 32'd3,    1'b1, ST_OK,        4'd0, 1'b0},
      '{MODE_QUERY, 32'd0,         4'd1,  32'd0,    1'b1, ST_OK,        4'd0, 1'b1},
      '{MODE_QUERY, 32'd0,         4'd3,  32'd0,    1'b1, ST_OK,        4'd0, 1'b0},
      // slot 3 lands exactly on its duration
      '{MODE_TICK,  32'd0,         4'd0,  32'd2,    1'b1, ST_OK,        4'd0, 1'b0},
      '{MODE_QUERY, 32'd0,         4'd3,  32'd0,    1'b1, ST_OK,        4'd0, 1'b1},
      '{MODE_TICK,  32'd0,         4'd0,  ALL_ONES, 1'b1, ST_OK,        4'd0, 1'b0},
      '{MODE_QUERY, 32'd0,         4'd2,  32'd0,    1'b1, ST_OK,        4'd0, 1'b1},
      // stop, then the slot is gone
      '{MODE_STOP,  ALL_ONES,      4'd2,  ALL_ONES, 1'b1, ST_OK,        4'd0, 1'b0},
      '{MODE_QUERY, 32'd0,         4'd2,  32'd0,    1'b1, ST_NOT_FOUND, 4'd0, 1'b0},
      // lowest free slot is reused
      '{MODE_START, 32'd7,         4'd0,  32'd0,    1'b1, ST_OK,        4'd2, 1'b0},
      // fill the rest of the pool
      '{MODE_START, 32'h8000_0000, 4'd0,  32'd0,    1'b0, ST_OK,        4'd0, 1'b0},
      '{MODE_START, 32'h0000_0100, 4'd0,  32'd0,    1'b0, ST_OK,        4'd0, 1'b0},
      '{MODE_START, 32'h5555_5555, 4'd0,  32'd0,    1'b0, ST_OK,        4'd0, 1'b0},
      '{MODE_START, 32'hAAAA_AAAA, 4'd0,  32'd0,    1'b0, ST_OK,        4'd0, 1'b0},
      '{MODE_START, 32'd2,         4'd0,  32'd0,    1'b0, ST_OK,        4'd0, 1'b0},
      '{MODE_START, 32'd10,        4'd0,  32'd0,    1'b1, ST_FULL,      4'd0, 1'b0},
      '{MODE_STOP,  32'd0,         4'd8,  32'd0,    1'b1, ST_OK,        4'd0, 1'b0}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [MODE_W-1:0] req_mode = '0;
   logic [DATA_W-1:0] req_duration = '0;
   logic [ID_W-1:0]   req_slot_id = '0;
   logic [DATA_W-1:0] req_tick_ms = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0]   rsp_new_id;
   logic              rsp_expired_flag;

   // row currently on the request port
   stim_row_type      offered_row = '0;

   // model of the slot pool
   bit                slot_on [NUM_SLOTS];
   logic [DATA_W-1:0] slot_elapsed_ms [NUM_SLOTS];
   logic [DATA_W-1:0] slot_limit_ms [NUM_SLOTS];

   pool_result_type   pending_results [$];
   int                error_count = 0;
   int                cycle_count = 0;
   int                items_accepted = 0;
   int                mode_count [4];
   int                status_count [4];
   int                burst_left = 0;
   bit                hold_request = 1'b0;

   timer_slot_pool_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_duration     (req_duration),
      .req_slot_id      (req_slot_id),
      .req_tick_ms      (req_tick_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_new_id       (rsp_new_id),
      .rsp_expired_flag (rsp_expired_flag)
   );

   always #5 clock = ~clock;

   // apply one item to the pool model and return its result
   function automatic pool_result_type pool_apply(mode_type mode,
                                                  logic [DATA_W-1:0] duration,
                                                  logic [ID_W-1:0] slot_id,
                                                  logic [DATA_W-1:0] tick_ms);
      pool_result_type   res;
      bit                taken;
      int                k;
      logic [DATA_W-1:0] left;
      res.status       = ST_OK;
      res.new_id       = '0;
      res.expired_flag = 1'b0;
      taken            = 1'b0;
      case (mode)
         MODE_START: begin
            if (duration == '0) begin
               res.status = ST_INVALID;
            end else begin
               res.status = ST_FULL;
               for (k = 0; k < NUM_SLOTS; k++) begin
                  if (!taken && !slot_on[k]) begin
                     taken              = 1'b1;
                     slot_on[k]         = 1'b1;
                     slot_elapsed_ms[k] = '0;
                     slot_limit_ms[k]   = duration;
                     res.new_id         = ID_W'(k + 1);
                     res.status         = ST_OK;
                  end
               end
            end
         end
         MODE_QUERY, MODE_STOP: begin
            if (slot_id == '0 || slot_id > NUM_SLOTS) begin
               res.status = ST_INVALID;
            end else if (!slot_on[slot_id-1]) begin
               res.status = ST_NOT_FOUND;
            end else if (mode == MODE_QUERY) begin
               res.expired_flag = (slot_elapsed_ms[slot_id-1] >= slot_limit_ms[slot_id-1]);
            end else begin
               slot_on[slot_id-1]         = 1'b0;
               slot_elapsed_ms[slot_id-1] = '0;
               slot_limit_ms[slot_id-1]   = '0;
            end
         end
         default: begin
            // tick: advance active slots, clamp at duration
            for (k = 0; k < NUM_SLOTS; k++) begin
               if (slot_on[k] && slot_elapsed_ms[k] < slot_limit_ms[k]) begin
                  left = slot_limit_ms[k] - slot_elapsed_ms[k];
                  if (tick_ms >= left) slot_elapsed_ms[k] = slot_limit_ms[k];
                  else slot_elapsed_ms[k] = slot_elapsed_ms[k] + tick_ms;
               end
            end
         end
      endcase
      return res;
   endfunction

   // random item, mostly well-formed ids and small times
   function automatic stim_row_type random_row();
      stim_row_type row;
      int           pick;
      row          = '0;
      row.duration = $urandom;
      row.slot_id  = ID_W'($urandom_range(0, 15));
      row.tick_ms  = $urandom;
      pick         = $urandom_range(0, 99);
      if (pick < 28) begin
         row.mode = MODE_START;
         case ($urandom_range(0, 19))
            0:       row.duration = '0;
            1:       row.duration = $urandom;
            2:       row.duration = ALL_ONES;
            default: row.duration = $urandom_range(1, 200);
         endcase
      end else if (pick < 76) begin
         row.mode = (pick < 52) ? MODE_QUERY : MODE_STOP;
         if ($urandom_range(0, 9) != 0) row.slot_id = ID_W'($urandom_range(1, NUM_SLOTS));
      end else begin
         row.mode = MODE_TICK;
         case ($urandom_range(0, 9))
            0:       row.tick_ms = $urandom;
            1:       row.tick_ms = '0;
            default: row.tick_ms = $urandom_range(1, 60);
         endcase
      end
      return row;
   endfunction

   // put one item on the port and hold it until accepted
   task automatic offer(input stim_row_type row);
      @(negedge clock);
      req_valid    <= 1'b1;
      req_mode     <= row.mode;
      req_duration <= row.duration;
      req_slot_id  <= row.slot_id;
      req_tick_ms  <= row.tick_ms;
      offered_row  <= row;
      do @(posedge clock); while (req_stall);
   endtask

   // drop valid for a number of cycles
   task automatic pause(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // bursts of random length with random gaps
   task automatic pace();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         pause(($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4));
      end
      burst_left--;
   endtask

   // stop sending until every outstanding result is back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // result checking and prediction on accepted items
   always @(posedge clock) begin
      pool_result_type want;
      pool_result_type predicted;
      cycle_count++;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            status_count[rsp_status]++;
            if (pending_results.size() == 0) begin
               $error("result with no item outstanding: status %0d new_id %0d expired_flag %0d",
                      rsp_status, rsp_new_id, rsp_expired_flag);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_new_id !== want.new_id) begin
                  $error("new_id: expected %0d, got %0d", want.new_id, rsp_new_id);
                  error_count++;
               end
               if (rsp_expired_flag !== want.expired_flag) begin
                  $error("expired_flag: expected %0d, got %0d", want.expired_flag,
                         rsp_expired_flag);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            predicted = pool_apply(mode_type'(req_mode), req_duration, req_slot_id,
                                   req_tick_ms);
            mode_count[req_mode]++;
            items_accepted++;
            if (offered_row.pinned) begin
               want.status       = offered_row.exp_status;
               want.new_id       = offered_row.exp_id;
               want.expired_flag = offered_row.exp_flag;
               pending_results.push_back(want);
            end else begin
               pending_results.push_back(predicted);
            end
         end
      end
   end

   // receiver: stall styles that change every so often, plus one long hold
   initial begin
      int style;
      int span;
      wait (!reset);
      forever begin
         style = $urandom_range(0, 3);
         span  = $urandom_range(16, 160);
         repeat (span) begin
            @(negedge clock);
            if (hold_request) begin
               rsp_stall <= 1'b1;
               repeat (HOLD_CYCLES) @(negedge clock);
               hold_request = 1'b0;
               rsp_stall <= 1'b0;
            end else begin
               case (style)
                  0:       rsp_stall <= 1'b0;
                  1:       rsp_stall <= ($urandom_range(0, 99) < 30);
                  2:       rsp_stall <= ($urandom_range(0, 99) < 80);
                  default: rsp_stall <= ~rsp_stall;
               endcase
            end
         end
      end
   end

   // watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("TB_ERROR");
      $finish;
   end

   // main sequence
   initial begin
      int seg;
      int n;
      foreach (slot_on[k]) begin
         slot_on[k]         = 1'b0;
         slot_elapsed_ms[k] = '0;
         slot_limit_ms[k]   = '0;
      end
      foreach (mode_count[k]) mode_count[k] = 0;
      foreach (status_count[k]) status_count[k] = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (n = 0; n < DIRECTED_N; n++) begin
         pace();
         offer(DIRECTED[n]);
      end
      drain();

      // random segments; the second one runs into a long output hold
      for (seg = 0; seg < SEGMENTS; seg++) begin
         if (seg == 1) hold_request = 1'b1;
         for (n = 0; n < SEG_ITEMS; n++) begin
            pace();
            offer(random_row());
         end
         drain();
      end

      repeat (NUM_SLOTS + 6) @(negedge clock);
      $display("items: %0d (start %0d, query %0d, stop %0d, tick %0d)", items_accepted,
               mode_count[MODE_START], mode_count[MODE_QUERY], mode_count[MODE_STOP],
               mode_count[MODE_TICK]);
      $display("results: ok %0d, invalid %0d, full %0d, not found %0d",
               status_count[ST_OK], status_count[ST_INVALID], status_count[ST_FULL],
               status_count[ST_NOT_FOUND]);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
         end
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/tsp_pkg.sv
rtl/tsp_datapath.sv
rtl/tsp_ctrl.sv
rtl/timer_slot_pool_core.sv
dv/timer_slot_pool_core_test.sv
